/* design/chroma_444_to_420_downsampler_defines.svh */
// Assertion macros for the chroma downsampler.
// Define ASSERT_OFF to compile the checks out.
`ifndef CHROMA_444_TO_420_DOWNSAMPLER_DEFINES_SVH
`define CHROMA_444_TO_420_DOWNSAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define C420_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define C420_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define C420_ASSERT(label, prop, msg)
`define C420_NEVER(label, cond, msg)

`endif

`endif

/* design/c420_pkg.sv */
package c420_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int SAMPLE_W  = 8;
    localparam int HSUM_W    = 10;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 12;
    localparam int BUF_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);
    localparam logic [CFG_W-1:0] MIN_SIZE     = CFG_W'(2);
    localparam logic [CFG_W-1:0] WIDTH_LIMIT  = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = CFG_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_e;

    // Line buffer write request.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [HSUM_W-1:0] data;
    } buf_wr_t;

    // Line buffer read request.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } buf_rd_t;

    // What the horizontal stage hands on for the vertical average.
    typedef struct packed {
        logic              produce;
        logic [HSUM_W-1:0] hsum;
        logic              frame_end;
    } item_t;

    // Drop the low bit, then clamp to the range 2..lim.
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                   input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] v;
        v = {r[CFG_W-1:1], 1'b0};
        if (v < MIN_SIZE)
            v = MIN_SIZE;
        if (v > lim)
            v = lim;
        return v;
    endfunction

endpackage

/* design/c420_linebuf.sv */
module c420_linebuf (
    input  logic                          clk,
    input  c420_pkg::buf_wr_t             wr,
    input  c420_pkg::buf_rd_t             rd,
    output logic [c420_pkg::HSUM_W-1:0]   rdata
);
    import c420_pkg::*;

    logic [HSUM_W-1:0] line_mem_reg [BUF_DEPTH];
    logic [HSUM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            line_mem_reg[wr.addr] <= wr.data;
    end

    // Read data holds until the next read request.
    always_ff @(posedge clk)
    begin
        if (rd.en)
            rdata_reg <= line_mem_reg[rd.addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/c420_hfilt.sv */
module c420_hfilt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [c420_pkg::SAMPLE_W-1:0]   sample,
    input  logic [c420_pkg::CFG_W-1:0]      w_eff,
    input  logic [c420_pkg::CFG_W-1:0]      h_eff,
    output c420_pkg::buf_wr_t               wr,
    output c420_pkg::buf_rd_t               rd,
    output c420_pkg::item_t                 item
);
    import c420_pkg::*;

    logic [CNT_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic [SAMPLE_W-1:0] left_reg, left_next;
    logic [SAMPLE_W-1:0] centre_reg, centre_next;

    logic              last_col;
    logic              last_row;
    logic              odd_col;
    logic              odd_row;
    logic [HSUM_W-1:0] hsum;

    always_comb
    begin
        last_col = (({1'b0, col_reg} + CFG_W'(1)) >= w_eff);
        last_row = (({1'b0, row_reg} + CFG_W'(1)) >= h_eff);
        odd_col  = col_reg[0];
        odd_row  = row_reg[0];
        hsum = HSUM_W'({2'b00, left_reg}) + {1'b0, centre_reg, 1'b0}
             + HSUM_W'({2'b00, sample});
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        centre_next = centre_reg;
        if (accept)
        begin
            if (!odd_col)
            begin
                centre_next = sample;
                if (col_reg == '0)
                    left_next = sample;
            end
            else
            begin
                left_next = sample;
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            centre_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            centre_reg <= centre_next;
        end
    end

    always_comb
    begin
        wr.en          = accept && odd_col && !odd_row;
        wr.addr        = col_reg[CNT_W-1:1];
        wr.data        = hsum;
        rd.en          = accept && odd_col && odd_row;
        rd.addr        = col_reg[CNT_W-1:1];
        item.produce   = rd.en;
        item.hsum      = hsum;
        item.frame_end = last_col && last_row;
    end

endmodule

/* design/c420_vavg.sv */
module c420_vavg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  c420_pkg::item_t                 item,
    input  logic [c420_pkg::HSUM_W-1:0]     rdata,
    input  logic                            out_stall,
    output logic                            hold,
    output logic                            out_valid,
    output logic [c420_pkg::SAMPLE_W-1:0]   sub_sample,
    output logic                            frame_end
);
    import c420_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic [HSUM_W-1:0]   s1_hsum_reg;
    logic                s1_end_reg;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] sub_reg;
    logic                end_reg;

    logic                load_out;
    logic [HSUM_W+1:0]   vsum;

    // (4a + 4b + 16) >> 5 equals (a + b + 4) >> 3.
    always_comb
    begin
        load_out = !out_valid_reg || !out_stall;
        hold     = s1_valid_reg && !load_out;
        vsum     = {2'b00, rdata} + {2'b00, s1_hsum_reg} + (HSUM_W+2)'(4);
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (accept)
            s1_valid_next = item.produce;
        else if (load_out)
            s1_valid_next = 1'b0;
        if (load_out)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.produce)
        begin
            s1_hsum_reg <= item.hsum;
            s1_end_reg  <= item.frame_end;
        end
        if (load_out && s1_valid_reg)
        begin
            sub_reg <= vsum[HSUM_W:3];
            end_reg <= s1_end_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sub_sample = sub_reg;
    assign frame_end  = end_reg;

endmodule

/* design/chroma_444_to_420_downsampler.sv */
// Chroma 4:4:4 to 4:2:0 downsampler. Samples of one chroma plane enter in raster
// order, one request per clock, and one subsampled value leaves for every 2x2
// block: a [1,2,1] horizontal filter centred on even columns (the first sample of
// a row stands in for its missing left neighbour), then the even-row and odd-row
// sums are averaged and rounded. The input takes one sample every cycle; it is
// stalled only while both the output register and the pending stage behind it
// hold results that the sink has not yet taken. The odd-column sample of an odd row
// that ends a block loads the pending stage as the line buffer data is registered;
// the output register then takes the result. That buffer is a 2048 x 10 bit
// memory holding the horizontal sums of the last even row; it needs no clearing
// after reset, as each entry is written on an even row before the odd row reads
// it. Line width and frame height are taken with their low bit cleared and
// clamped to 2..4096; write them only while the block is idle.
module chroma_444_to_420_downsampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [c420_pkg::SAMPLE_W-1:0]     sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [c420_pkg::SAMPLE_W-1:0]     sub_sample,
    output logic                              frame_end,
    input  logic                              cfg_we,
    input  logic [c420_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c420_pkg::CFG_W-1:0]        cfg_data
);
    import c420_pkg::*;

`include "chroma_444_to_420_downsampler_defines.svh"

    logic [CFG_W-1:0] line_width_reg, line_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;

    logic              accept;
    logic              hold;
    logic [CFG_W-1:0]  w_eff;
    logic [CFG_W-1:0]  h_eff;
    buf_wr_t           buf_wr;
    buf_rd_t           buf_rd;
    item_t             item;
    logic [HSUM_W-1:0] buf_rdata;

    // Configuration register decode.
    always_comb
    begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_LINE_WIDTH:   line_width_next   = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else
        begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    always_comb
    begin
        w_eff    = eff_size(line_width_reg, WIDTH_LIMIT);
        h_eff    = eff_size(frame_height_reg, HEIGHT_LIMIT);
        in_stall = hold;
        accept   = in_valid && !hold;
    end

    // Counters and horizontal filter; they issue the line buffer requests.
    c420_hfilt u_hfilt (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .w_eff  (w_eff),
        .h_eff  (h_eff),
        .wr     (buf_wr),
        .rd     (buf_rd),
        .item   (item)
    );

    // Reads and writes fall in different rows, so the registered read never meets
    // a write to the same entry and no forwarding is needed.
    c420_linebuf u_linebuf (
        .clk   (clk),
        .wr    (buf_wr),
        .rd    (buf_rd),
        .rdata (buf_rdata)
    );

    // Pending stage, vertical average and output register.
    c420_vavg u_vavg (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .rdata      (buf_rdata),
        .out_stall  (out_stall),
        .hold       (hold),
        .out_valid  (out_valid),
        .sub_sample (sub_sample),
        .frame_end  (frame_end)
    );

    // The input may only be held back while a result waits at the output.
    `C420_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "bad input stall")
    // One request at a time touches the line buffer.
    `C420_NEVER(a_buf_excl, buf_wr.en && buf_rd.en, "buffer read and write together")
    // A read is issued only for an accepted sample, so its data is never lost.
    `C420_ASSERT(a_read_accept, buf_rd.en |-> accept, "read without accepted sample")

endmodule
